/* hw/rtl/arithmetic_encoder_step_core_macros.svh */
// Assertion macros shared by the arithmetic encoder RTL.
// Every user of these macros must have i_clk and i_rst_n in scope.
`ifndef ARITHMETIC_ENCODER_STEP_CORE_MACROS_SVH
`define ARITHMETIC_ENCODER_STEP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARENC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARENC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/arenc_pkg.sv */
// Shared types and constants for the arithmetic encoder.
// No dependencies; used by arenc_ctrl, arenc_dp and the top level.
package arenc_pkg;

    localparam int CODE_BITS_DEF    = 16;
    localparam int PENDING_BITS_DEF = 16;
    localparam int SYM_W            = 14;
    localparam int FOLLOW_W         = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int NRES_W           = $clog2(MAX_RESULTS + 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the symbol counts
        logic mul;     // form both products, start the divider
        logic div;     // one restoring division step
        logic apply;   // narrow the interval from the quotients
        logic step;    // one renormalization shift
        logic flush;   // release the held result as the final one
        logic bad;     // emit the illegal-symbol result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_sym;     // latched counts are illegal
        logic div_last;    // the division step under way is the final one
        logic emit;        // top bits agree: a bit settles
        logic under;       // bounds straddle the middle
        logic cap;         // shift or result limit reached
        logic hold_valid;  // a result waits in the hold register
        logic out_free;    // output register can take a result this cycle
    } t_status;

endpackage

/* hw/rtl/arenc_dp.sv */
// Datapath of the arithmetic encoder: bounds, products, serial divider,
// renormalization and the result registers. Depends on arenc_pkg.
`include "arithmetic_encoder_step_core_macros.svh"

module arenc_dp #(
    parameter int CODE_BITS    = arenc_pkg::CODE_BITS_DEF,
    parameter int PENDING_BITS = arenc_pkg::PENDING_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  arenc_pkg::t_cmd               i_cmd,
    output arenc_pkg::t_status            o_status,
    input  logic [arenc_pkg::SYM_W-1:0]   i_sym_low,
    input  logic [arenc_pkg::SYM_W-1:0]   i_sym_high,
    input  logic [arenc_pkg::SYM_W-1:0]   i_total_scale,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_out_bit,
    output logic [arenc_pkg::FOLLOW_W-1:0] o_follow_count,
    output logic                          o_out_last,
    output logic                          o_out_bad
);

    localparam int SW     = arenc_pkg::SYM_W;
    localparam int FW     = arenc_pkg::FOLLOW_W;
    localparam int NW     = arenc_pkg::NRES_W;
    localparam int DIV_W  = CODE_BITS + 1 + SW;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam int SH_W   = $clog2(CODE_BITS + 1);

    logic [SW-1:0]           r_lc, r_hc, r_sc;
    logic [CODE_BITS-1:0]    r_low, r_high;
    logic [PENDING_BITS-1:0] r_pending;
    logic [DIV_W-1:0]        r_qa, r_qb;
    logic [SW-1:0]           r_ra, r_rb;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [SH_W-1:0]         r_shifts;
    logic [NW-1:0]           r_nres;
    logic                    r_hold_valid, r_hold_bit;
    logic [FW-1:0]           r_hold_follow;
    logic                    r_out_valid, r_out_bit, r_out_last, r_out_bad;
    logic [FW-1:0]           r_out_follow;

    logic [CODE_BITS:0]      range_w;
    logic [SW:0]             rem_a, rem_b;
    logic                    ge_a, ge_b;
    logic                    emit, under;
    logic [CODE_BITS-1:0]    low_m, high_m;
    logic [FW-1:0]           follow;

    // Interval width, one more bit than the bounds so a full range fits.
    assign range_w = {1'b0, r_high} - {1'b0, r_low} + (CODE_BITS + 1)'(1);

    // Restoring division, both quotients against the same scale.
    assign rem_a = {r_ra, r_qa[DIV_W-1]};
    assign rem_b = {r_rb, r_qb[DIV_W-1]};
    assign ge_a  = rem_a >= {1'b0, r_sc};
    assign ge_b  = rem_b >= {1'b0, r_sc};

    // Renormalization decision on the current bounds.
    assign emit   = r_high[CODE_BITS-1] == r_low[CODE_BITS-1];
    assign under  = r_low[CODE_BITS-2] & ~r_high[CODE_BITS-2];
    assign low_m  = (!emit && under) ? {2'b00, r_low[CODE_BITS-3:0]} : r_low;
    assign high_m = (!emit && under) ? {r_high[CODE_BITS-1], 1'b1, r_high[CODE_BITS-3:0]}
                                     : r_high;
    assign follow = FW'(r_pending);

    always_comb begin
        o_status.bad_sym    = (r_sc == '0) || (r_hc <= r_lc) || (r_hc > r_sc);
        o_status.div_last   = r_dcnt == DCNT_W'(DIV_W - 1);
        o_status.emit       = emit;
        o_status.under      = under;
        o_status.cap        = (r_shifts == SH_W'(CODE_BITS)) ||
                              (r_nres == NW'(arenc_pkg::MAX_RESULTS));
        o_status.hold_valid = r_hold_valid;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lc <= i_sym_low;
            r_hc <= i_sym_high;
            r_sc <= i_total_scale;
        end
        if (i_cmd.mul) begin
            r_qa <= DIV_W'(range_w) * DIV_W'(r_lc);
            r_qb <= DIV_W'(range_w) * DIV_W'(r_hc);
            r_ra <= '0;
            r_rb <= '0;
        end else if (i_cmd.div) begin
            r_qa <= {r_qa[DIV_W-2:0], ge_a};
            r_qb <= {r_qb[DIV_W-2:0], ge_b};
            r_ra <= ge_a ? SW'(rem_a - {1'b0, r_sc}) : rem_a[SW-1:0];
            r_rb <= ge_b ? SW'(rem_b - {1'b0, r_sc}) : rem_b[SW-1:0];
        end
        if (i_cmd.step && emit) begin
            r_hold_bit    <= r_high[CODE_BITS-1];
            r_hold_follow <= follow;
        end
        if (i_cmd.bad) begin
            r_out_bit    <= 1'b0;
            r_out_follow <= '0;
            r_out_last   <= 1'b1;
            r_out_bad    <= 1'b1;
        end else if (i_cmd.flush || (i_cmd.step && emit && r_hold_valid)) begin
            r_out_bit    <= r_hold_bit;
            r_out_follow <= r_hold_follow;
            r_out_last   <= i_cmd.flush;
            r_out_bad    <= 1'b0;
        end
    end

    // Control and coder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= '0;
            r_high       <= '1;
            r_pending    <= '0;
            r_dcnt       <= '0;
            r_shifts     <= '0;
            r_nres       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.mul) begin
                r_dcnt <= '0;
            end else if (i_cmd.div) begin
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            if (i_cmd.apply) begin
                r_low    <= r_low + r_qa[CODE_BITS-1:0];
                r_high   <= r_low + r_qb[CODE_BITS-1:0] - CODE_BITS'(1);
                r_shifts <= '0;
                r_nres   <= '0;
            end else if (i_cmd.step) begin
                r_low    <= {low_m[CODE_BITS-2:0], 1'b0};
                r_high   <= {high_m[CODE_BITS-2:0], 1'b1};
                r_shifts <= r_shifts + SH_W'(1);
                if (emit) begin
                    r_pending    <= '0;
                    r_nres       <= r_nres + NW'(1);
                    r_hold_valid <= 1'b1;
                end else if (r_pending != '1) begin
                    r_pending <= r_pending + PENDING_BITS'(1);
                end
            end
            if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end
            if (i_cmd.bad || i_cmd.flush || (i_cmd.step && emit && r_hold_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_bit      = r_out_bit;
    assign o_follow_count = r_out_follow;
    assign o_out_last     = r_out_last;
    assign o_out_bad      = r_out_bad;

    `ARENC_ASSERT_NOW(a_nres_cap, 1'b1, r_nres <= NW'(arenc_pkg::MAX_RESULTS), "result cap overrun")
    `ARENC_ASSERT_NEXT(a_pend_sat, i_cmd.step && !emit && (&r_pending), &r_pending, "pending wrapped")
    `ARENC_ASSERT_NEXT(a_out_hold, r_out_valid && !i_out_ready, r_out_valid, "result dropped")

endmodule

/* hw/rtl/arenc_ctrl.sv */
// Controller of the arithmetic encoder: sequences check, multiply, division,
// narrowing, renormalization and result release. Depends on arenc_pkg.
`include "arithmetic_encoder_step_core_macros.svh"

module arenc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  arenc_pkg::t_status i_status,
    output arenc_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_RENORM = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;
    localparam logic [2:0] S_BAD    = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.bad_sym) begin
                    n_state = S_BAD;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_RENORM;
            end
            S_RENORM: begin
                if (i_status.cap || (!i_status.emit && !i_status.under)) begin
                    n_state = S_FLUSH;
                end else if (!(i_status.emit && i_status.hold_valid && !i_status.out_free)) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!i_status.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_BAD: begin
                if (i_status.out_free) begin
                    o_cmd.bad = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ARENC_ASSERT_NOW(a_push_room, o_cmd.step && i_status.emit && i_status.hold_valid, i_status.out_free, "result pushed into a full output register")
    `ARENC_ASSERT_NOW(a_idle_no_hold, r_state == S_IDLE, !i_status.hold_valid, "result left in hold register at idle")
    `ARENC_ASSERT_NEXT(a_div_to_apply, r_state == S_DIV && i_status.div_last, r_state == S_APPLY, "division did not hand over to narrowing")

endmodule

/* hw/rtl/arithmetic_encoder_step_core.sv */
// Top level of the 16-bit integer arithmetic encoder, one symbol per transfer.
// Depends on arenc_pkg, arenc_ctrl and arenc_dp.
//
//   Channel   Direction  tdata (low bit first)                        Side bands
//   s_axis    in         sym_low[13:0], sym_high[13:0], total_scale    -
//   m_axis    out        out_bit, follow_count[15:0]                   tlast=last, tuser=bad_symbol
//
// A symbol is checked, multiplied and divided by the serial restoring divider that
// forms both quotients side by side (31 division steps at the default width), then
// narrowed. Renormalization makes one shift per cycle (at most CODE_BITS) unless a
// settled bit waits for a busy output register; a final check and the release of the
// held result, if any, close the symbol. An illegal symbol is flagged instead.
// Reset is synchronous and active low; it sets low bound to zero, high bound to
// all ones and the pending count to zero. A stalled result side holds the coder
// only when a new result needs the output register; the next symbol is taken
// while the final result of the previous one still waits there.
module arithmetic_encoder_step_core #(
    parameter int CODE_BITS    = arenc_pkg::CODE_BITS_DEF,
    parameter int PENDING_BITS = arenc_pkg::PENDING_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sym_low[13:0], sym_high[27:14], total_scale[41:28]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_bit[0], follow_count[16:1], zero fill
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // bad_symbol[0]
);

    localparam int SW = arenc_pkg::SYM_W;

    arenc_pkg::t_cmd    cmd;
    arenc_pkg::t_status status;

    logic                          out_bit;
    logic [arenc_pkg::FOLLOW_W-1:0] follow_count;

    // The controller owns sequencing; the datapath owns all coder and result registers.
    arenc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    arenc_dp #(
        .CODE_BITS    (CODE_BITS),
        .PENDING_BITS (PENDING_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sym_low      (s_axis_tdata[SW-1:0]),
        .i_sym_high     (s_axis_tdata[2*SW-1:SW]),
        .i_total_scale  (s_axis_tdata[3*SW-1:2*SW]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_bit      (out_bit),
        .o_follow_count (follow_count),
        .o_out_last     (m_axis_tlast),
        .o_out_bad      (m_axis_tuser)
    );

    // Pack the result fields; the upper bits are zero fill to a byte boundary.
    assign m_axis_tdata = {7'd0, follow_count, out_bit};

endmodule

/* tb/tb.sv */
// Self-checking testbench for arithmetic_encoder_step_core: streams symbols in,
// predicts the settled code bits and follow counts, and checks every result transfer.
// Depends on arenc_pkg and the RTL of arithmetic_encoder_step_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYM_MAX      = (1 << arenc_pkg::SYM_W) - 1;
    localparam int CODE_W       = arenc_pkg::CODE_BITS_DEF;
    localparam int MID_POINT    = 1 << (CODE_W - 1);
    localparam int DRAIN_CYCLES = 64;   // longer than the busiest symbol with no result

    // One symbol as it travels on the slave side; sc ends up in the highest bits.
    typedef struct packed {
        bit [arenc_pkg::SYM_W-1:0] sc;
        bit [arenc_pkg::SYM_W-1:0] hc;
        bit [arenc_pkg::SYM_W-1:0] lc;
    } sym_t;

    typedef struct {
        bit                          out_bit;
        bit [arenc_pkg::FOLLOW_W-1:0] follow;
        bit                          last;
        bit                          bad;
    } code_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // sym_low[13:0], sym_high[27:14], total_scale[41:28]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // out_bit[0], follow_count[16:1], zero fill
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // bad_symbol[0]

    // Coder state as the predictor sees it, advanced at each accepted symbol.
    bit [CODE_W-1:0] low_b = '0;
    bit [CODE_W-1:0] high_b = '1;
    bit [15:0]       pend = '0;

    sym_t  symbol_q[$];
    sym_t  sym_on_bus;
    code_t bits_due[$];
    int    s_idle_pct = 19;
    int    r_idle_pct = 65;
    int    mismatches = 0;

    arithmetic_encoder_step_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Narrows the interval for one symbol, renormalizes and queues the code bits
    // it settles. The newest bit is held back so that it can carry tlast.
    task automatic predict_symbol(input sym_t s);
        bit [15:0] diff;
        bit [31:0] span;
        bit [31:0] q_lo;
        bit [31:0] q_hi;
        bit [CODE_W-1:0] lo;
        bit [CODE_W-1:0] hi;
        int    n_res;
        int    sh;
        bit    settled;
        bit    have_held;
        code_t held;
        n_res = 0;
        settled = 1'b0;
        have_held = 1'b0;
        held = '{out_bit: 1'b0, follow: '0, last: 1'b0, bad: 1'b0};
        if (s.sc == '0 || s.hc <= s.lc || s.hc > s.sc) begin
            // Illegal counts: one flagged result, state untouched.
            bits_due.push_back('{out_bit: 1'b0, follow: '0, last: 1'b1, bad: 1'b1});
            return;
        end
        diff = high_b - low_b;
        span = 32'(diff) + 32'd1;
        q_hi = (span * s.hc) / s.sc;
        q_lo = (span * s.lc) / s.sc;
        hi = low_b + q_hi[CODE_W-1:0] - 1'b1;
        lo = low_b + q_lo[CODE_W-1:0];
        sh = 0;
        while (sh < CODE_W && n_res < arenc_pkg::MAX_RESULTS && !settled) begin
            if (hi[CODE_W-1] == lo[CODE_W-1]) begin
                if (have_held)
                    bits_due.push_back(held);
                held = '{out_bit: hi[CODE_W-1], follow: pend, last: 1'b0, bad: 1'b0};
                have_held = 1'b1;
                n_res++;
                pend = '0;
            end else if (lo[CODE_W-2] && !hi[CODE_W-2]) begin
                // Underflow: the count sticks at its maximum.
                if (pend != '1)
                    pend++;
                lo[CODE_W-2] = 1'b0;
                hi[CODE_W-2] = 1'b1;
            end else begin
                settled = 1'b1;
            end
            if (!settled) begin
                lo = {lo[CODE_W-2:0], 1'b0};
                hi = {hi[CODE_W-2:0], 1'b1};
                sh++;
            end
        end
        low_b = lo;
        high_b = hi;
        if (have_held) begin
            held.last = 1'b1;
            bits_due.push_back(held);
        end
    endtask

    // Sender: presents queued symbols, idling at random between transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_symbol(sym_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (symbol_q.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                    sym_on_bus = symbol_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, sym_on_bus};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks each result transfer in order.
    always @(posedge i_clk) begin
        code_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= r_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (bits_due.size() == 0) begin
                    $error("result transfer with no result expected");
                    mismatches++;
                end else begin
                    want = bits_due.pop_front();
                    if (m_axis_tdata[0] !== want.out_bit) begin
                        $error("out_bit: expected %0d, got %0d", want.out_bit, m_axis_tdata[0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[16:1] !== want.follow) begin
                        $error("follow_count: expected %0d, got %0d",
                               want.follow, m_axis_tdata[16:1]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.bad) begin
                        $error("bad_symbol: expected %0d, got %0d", want.bad, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic queue_sym(input int lc, input int hc, input int sc);
        symbol_q.push_back('{sc: sc[arenc_pkg::SYM_W-1:0], hc: hc[arenc_pkg::SYM_W-1:0],
                             lc: lc[arenc_pkg::SYM_W-1:0]});
    endtask

    // Returns once every queued symbol has been taken, so the predicted state is current.
    task automatic wait_input_idle();
        do
            @(negedge i_clk);
        while (symbol_q.size() != 0 || s_axis_tvalid);
    endtask

    task automatic drain();
        wait_input_idle();
        while (bits_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // A symbol whose sub-interval sits just across the middle, so every shift
    // of the step is an underflow. The bounds always straddle the middle
    // between symbols, which keeps the offset below positive.
    task automatic queue_straddle();
        bit [15:0] diff;
        int span;
        int mid;
        wait_input_idle();
        diff = high_b - low_b;
        span = int'(diff) + 1;
        mid = MID_POINT - int'(low_b);
        queue_sym((mid * SYM_MAX + span - 1) / span - 1,
                  ((mid + 1) * SYM_MAX + span - 1) / span, SYM_MAX);
    endtask

    // A one-count symbol that, where the interval allows it, collapses the bounds
    // onto a single value, so all shifts settle bits and the result limit is hit.
    task automatic queue_tight();
        bit [15:0] diff;
        longint span;
        int lc;
        int tries;
        wait_input_idle();
        diff = high_b - low_b;
        span = longint'(diff) + 1;
        lc = $urandom_range(SYM_MAX - 1);
        tries = 0;
        while (tries < SYM_MAX && (span * (lc + 1)) / SYM_MAX - (span * lc) / SYM_MAX != 1) begin
            lc = (lc == SYM_MAX - 1) ? 0 : lc + 1;
            tries++;
        end
        queue_sym(lc, lc + 1, SYM_MAX);
    endtask

    task automatic queue_random();
        int roll;
        int lc;
        int hc;
        int sc;
        roll = $urandom_range(99);
        if (roll < 40) begin
            sc = $urandom_range(SYM_MAX, 1);
            hc = $urandom_range(sc, 1);
            lc = $urandom_range(hc - 1);
            queue_sym(lc, hc, sc);
        end else if (roll < 55) begin
            // Narrow symbol: settles many bits at once.
            sc = ($urandom_range(1) == 1) ? SYM_MAX : $urandom_range(SYM_MAX, 1);
            lc = $urandom_range(sc - 1);
            queue_sym(lc, lc + 1, sc);
        end else if (roll < 70) begin
            queue_straddle();
        end else if (roll < 80) begin
            queue_tight();
        end else begin
            case ($urandom_range(2))
                0: queue_sym($urandom, $urandom, 0);
                1: begin
                    lc = $urandom_range(SYM_MAX);
                    queue_sym(lc, $urandom_range(lc), $urandom_range(SYM_MAX, 1));
                end
                default: begin
                    sc = $urandom_range(SYM_MAX - 1, 1);
                    hc = $urandom_range(SYM_MAX, sc + 1);
                    queue_sym($urandom_range(hc - 1), hc, sc);
                end
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed symbols: whole interval (nothing settles), every kind of
        // illegal count, field extremes, and the slivers at both ends.
        queue_sym(0, 1, 1);
        queue_sym(0, 0, 0);
        queue_sym(5, 9, 0);
        queue_sym(100, 100, 200);
        queue_sym(300, 200, 1000);
        queue_sym(0, SYM_MAX, SYM_MAX - 1);
        queue_sym(SYM_MAX, SYM_MAX, SYM_MAX);
        queue_sym(SYM_MAX - 1, SYM_MAX, SYM_MAX);
        queue_sym(0, 1, SYM_MAX);
        queue_sym(0, SYM_MAX, SYM_MAX);
        queue_sym(1, 2, 3);
        queue_sym(2, 3, 3);
        queue_sym(8191, 8192, SYM_MAX);
        // Pending bits built up, then released with a full run of settled bits.
        repeat (3) queue_straddle();
        queue_tight();
        queue_straddle();
        queue_sym(0, 1, SYM_MAX);
        queue_tight();
        queue_tight();

        repeat (50) queue_random();
        drain();

        s_idle_pct = 65;
        r_idle_pct = 19;
        repeat (50) queue_random();
        drain();

        s_idle_pct = 0;
        r_idle_pct = 0;
        repeat (50) queue_random();

        // Build up a long run of pending bits with underflow symbols, then
        // settle a bit to read the count back.
        repeat (8) queue_straddle();
        queue_tight();
        queue_sym(0, 1, SYM_MAX);
        repeat (10) queue_random();

        drain();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
